// ----- rtl/qec_pkg.sv -----
// ----------------------------------------------------------------------------
// qec_pkg
// Shared types, operation codes and the quadrature step table for the
// quadrature encoder counter.
// ----------------------------------------------------------------------------
package qec_pkg;

  // Operation codes carried in the op field of a request.
  localparam logic [2:0] OP_LEFT_PIN   = 3'd0;
  localparam logic [2:0] OP_RIGHT_EDGE = 3'd1;
  localparam logic [2:0] OP_READ       = 3'd2;
  localparam logic [2:0] OP_READ_CLEAR = 3'd3;
  localparam logic [2:0] OP_VELOCITY   = 3'd4;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned STEP_W = 3;

  // One input request.
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] left_pins;
    logic       which_counter;
  } qec_in_t;

  // One result.
  typedef struct packed {
    logic signed [CNT_W-1:0] left_value;
    logic signed [CNT_W-1:0] right_value;
  } qec_out_t;

  // Signed step for a transition, indexed by {old pins, new pins}.
  // An invalid double change gives +2.
  function automatic logic signed [STEP_W-1:0] step_lookup(input logic [3:0] idx);
    logic signed [STEP_W-1:0] s;
    case (idx)
      4'd0, 4'd5, 4'd10, 4'd15: s = 3'sd0;
      4'd1, 4'd7, 4'd8, 4'd14:  s = 3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -3'sd1;
      4'd3, 4'd6, 4'd9, 4'd12:  s = 3'sd2;
      default:                  s = 3'sd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/qec_core.sv -----
// ----------------------------------------------------------------------------
// qec_core
// Counter state and the per-request update. The result is formed from the
// state before the update; the state advances when fire is high.
// ----------------------------------------------------------------------------
module qec_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  qec_pkg::qec_in_t item,
  output qec_pkg::qec_out_t result
);
  import qec_pkg::*;

  logic [1:0]              prev_pins_r, prev_pins_nxt;
  logic signed [STEP_W-1:0] last_step_r, last_step_nxt;
  logic [CNT_W-1:0] left_count_r, left_count_nxt;
  logic [CNT_W-1:0] right_count_r, right_count_nxt;
  logic [CNT_W-1:0] left_total_r, left_total_nxt;
  logic [CNT_W-1:0] right_total_r, right_total_nxt;
  logic [CNT_W-1:0] left_snap_r, left_snap_nxt;
  logic [CNT_W-1:0] right_snap_r, right_snap_nxt;

  logic signed [STEP_W-1:0] new_step;
  logic [CNT_W-1:0]         new_step_ext;
  logic [CNT_W-1:0]         last_step_ext;
  logic [CNT_W-1:0]         lv, rv;

  // Table lookup and sign extension of the steps.
  assign new_step      = step_lookup({prev_pins_r, item.left_pins});
  assign new_step_ext  = {{(CNT_W-STEP_W){new_step[STEP_W-1]}}, new_step};
  assign last_step_ext = {{(CNT_W-STEP_W){last_step_r[STEP_W-1]}}, last_step_r};

  // Next state and result for the current request.
  always_comb begin
    prev_pins_nxt   = prev_pins_r;
    last_step_nxt   = last_step_r;
    left_count_nxt  = left_count_r;
    right_count_nxt = right_count_r;
    left_total_nxt  = left_total_r;
    right_total_nxt = right_total_r;
    left_snap_nxt   = left_snap_r;
    right_snap_nxt  = right_snap_r;
    lv = '0;
    rv = '0;
    case (item.op)
      OP_LEFT_PIN: begin
        last_step_nxt  = new_step;
        left_count_nxt = left_count_r + new_step_ext;
        left_total_nxt = left_total_r + new_step_ext;
        prev_pins_nxt  = item.left_pins;
      end
      OP_RIGHT_EDGE: begin
        right_count_nxt = right_count_r + last_step_ext;
        right_total_nxt = right_total_r + last_step_ext;
      end
      OP_READ, OP_READ_CLEAR: begin
        if (item.which_counter) begin
          lv = left_total_r;
          rv = right_total_r;
          if (item.op == OP_READ_CLEAR) begin
            left_total_nxt  = '0;
            right_total_nxt = '0;
          end
        end else begin
          lv = left_count_r;
          rv = right_count_r;
          if (item.op == OP_READ_CLEAR) begin
            left_count_nxt  = '0;
            right_count_nxt = '0;
          end
        end
      end
      OP_VELOCITY: begin
        lv = left_count_r - left_snap_r;
        rv = right_count_r - right_snap_r;
        left_snap_nxt  = left_count_r;
        right_snap_nxt = right_count_r;
      end
      default: begin
        lv = '0;
        rv = '0;
      end
    endcase
  end

  assign result.left_value  = lv;
  assign result.right_value = rv;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r   <= '0;
      last_step_r   <= '0;
      left_count_r  <= '0;
      right_count_r <= '0;
      left_total_r  <= '0;
      right_total_r <= '0;
      left_snap_r   <= '0;
      right_snap_r  <= '0;
    end else if (fire) begin
      prev_pins_r   <= prev_pins_nxt;
      last_step_r   <= last_step_nxt;
      left_count_r  <= left_count_nxt;
      right_count_r <= right_count_nxt;
      left_total_r  <= left_total_nxt;
      right_total_r <= right_total_nxt;
      left_snap_r   <= left_snap_nxt;
      right_snap_r  <= right_snap_nxt;
    end
  end

endmodule

// ----- rtl/qec_out_reg.sv -----
// ----------------------------------------------------------------------------
// qec_out_reg
// Result register with valid/ready handshake toward the result channel.
// ----------------------------------------------------------------------------
module qec_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  qec_pkg::qec_out_t load_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output qec_pkg::qec_out_t out_data
);
  import qec_pkg::*;

  logic     valid_r, valid_nxt;
  qec_out_t data_r;

  // The register can take a new result when empty or being drained.
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/quadrature_encoder_counter.sv -----
// ----------------------------------------------------------------------------
// quadrature_encoder_counter
// x4 quadrature decoder of the left channel with clearable, total and
// velocity counters for both sides.
//
//   Channel | Direction | Handshake            | Payload
//   in      | input     | in_valid / in_ready  | in_data  (qec_in_t)
//   out     | output    | out_valid / out_ready| out_data (qec_out_t)
//
// One request is accepted per cycle while the result channel does not stall;
// each request gives one result, registered first in the input register
// and then in the result register; the counter update between them is
// one 32-bit add or subtract.
// Synchronous active-low reset zeroes all counters and empties both stages.
// A stalled result holds; the input register then fills and in_ready drops.
// ----------------------------------------------------------------------------
module quadrature_encoder_counter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qec_pkg::qec_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qec_pkg::qec_out_t out_data
);
  import qec_pkg::*;

  logic     in_valid_r, in_valid_nxt;
  qec_in_t  in_data_r;
  logic     out_free;
  logic     advance;
  qec_out_t core_result;

  // A held request moves to the result register when it has room.
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  // Input register.
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Counter state and update.
  qec_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_data_r),
    .result (core_result)
  );

  // Result register.
  qec_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_data (core_result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/qec_checker.sv -----
// ----------------------------------------------------------------------------
// qec_checker
// Port-level checks of the quadrature encoder counter, bound to the top level.
// ----------------------------------------------------------------------------
module qec_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input qec_pkg::qec_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input qec_pkg::qec_out_t out_data
);
  import qec_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A request that waits for in_ready stays presented and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  // With no result pending the block always takes a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty result stage");

  // A request taken into an empty block shows a result after passing the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid |=> ##1 out_valid)
    else $error("result missing after request");

  // Reset empties the result stage.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quadrature_encoder_counter qec_checker u_qec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
